[hw/rtl/qrs_pkg.sv]
`timescale 1ns / 1ps
package qrs_pkg;

  // Internal datapath widths cover the widest coefficient (32 bits).
  localparam int MagW  = 32;
  localparam int DiscW = 66;
  localparam int RadW  = 64;
  localparam int RootW = 32;
  localparam int NumW  = 64;
  localparam int DivW  = 66;
  localparam int QuoW  = 33;
  localparam int SqrtSteps = RadW / 2;
  localparam int DivSteps  = QuoW;

  localparam logic [DiscW-1:0] SmallLimit = DiscW'(1) << 48;
  localparam logic [QuoW-1:0]  QuoMaxPos  = 33'h0_7FFF_FFFF;
  localparam logic [QuoW-1:0]  QuoMinMag  = 33'h0_8000_0000;
  localparam logic signed [31:0] ValMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ValMin = 32'sh8000_0000;
  localparam int ShiftSmall = 7;
  localparam int ShiftLarge = 15;

  typedef enum logic [1:0] {
    CASE_REAL    = 2'd0,
    CASE_DOUBLE  = 2'd1,
    CASE_COMPLEX = 2'd2,
    CASE_AZERO   = 2'd3
  } root_case_t;

  // One classified request between front and back.
  typedef struct packed {
    root_case_t            rcase;
    logic                  a_neg;
    logic [MagW-1:0]       a_mag;
    logic signed [MagW-1:0] b;
    logic                  is_small;
    logic [RadW-1:0]       rad;
  } item_t;

  function automatic logic [MagW-1:0] mag(input logic signed [MagW-1:0] v);
    mag = v[MagW-1] ? MagW'(-v) : MagW'(v);
  endfunction

endpackage

[hw/rtl/qrs_in_if.sv]
`timescale 1ns / 1ps
interface qrs_in_if #(parameter int COEF_WIDTH = 16) ();
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coef_a;
  logic signed [COEF_WIDTH-1:0] coef_b;
  logic signed [COEF_WIDTH-1:0] coef_c;

  modport source(output valid, coef_a, coef_b, coef_c, input ready);
  modport sink(input valid, coef_a, coef_b, coef_c, output ready);
endinterface

[hw/rtl/qrs_out_if.sv]
`timescale 1ns / 1ps
interface qrs_out_if ();
  logic               valid;
  logic               ready;
  logic [1:0]         root_case;
  logic signed [31:0] first_value;
  logic signed [31:0] second_value;
  logic               saturated;

  modport source(output valid, root_case, first_value, second_value, saturated,
                 input ready);
  modport sink(input valid, root_case, first_value, second_value, saturated,
               output ready);
endinterface

[hw/rtl/qrs_front.sv]
`timescale 1ns / 1ps
module qrs_front #(
  parameter int COEF_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  qrs_in_if.sink         coefs,
  output logic           push,
  output qrs_pkg::item_t item,
  input  logic           full
);

  logic                      v0, v1, adv0, adv1;
  logic signed [31:0]        a0, b0, c0;
  logic [63:0]               bsq, m;
  logic                      a_neg, c_neg, a_zero, c_zero;
  logic [31:0]               a_mag;
  logic signed [31:0]        b1;
  logic [63:0]               bsq_c, m_c;
  logic [qrs_pkg::DiscW-1:0] four_ac, bsq_w, dmag;
  logic                      dneg, same;

  assign adv1 = !v1 || !full;
  assign adv0 = !v0 || adv1;
  assign coefs.ready = adv0;
  assign push = v1 && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (adv0) v0 <= coefs.valid;
      if (adv1) v1 <= v0;
    end
  end

  assign bsq_c = qrs_pkg::mag(b0) * qrs_pkg::mag(b0);
  assign m_c   = qrs_pkg::mag(a0) * qrs_pkg::mag(c0);

  always_ff @(posedge clk) begin
    if (adv0) begin
      a0 <= 32'($signed(coefs.coef_a[COEF_WIDTH-1:0]));
      b0 <= 32'($signed(coefs.coef_b[COEF_WIDTH-1:0]));
      c0 <= 32'($signed(coefs.coef_c[COEF_WIDTH-1:0]));
    end
    if (adv1) begin
      bsq    <= bsq_c;
      m      <= m_c;
      a_neg  <= a0[31];
      c_neg  <= c0[31];
      a_zero <= (a0 == 32'sd0);
      c_zero <= (c0 == 32'sd0);
      a_mag  <= qrs_pkg::mag(a0);
      b1     <= b0;
    end
  end

  // Discriminant magnitude and sign from b^2 and 4|a||c|.
  always_comb begin
    four_ac = {m, 2'b00};
    bsq_w   = {2'b00, bsq};
    same    = !c_zero && (a_neg == c_neg);
    dneg    = 1'b0;
    if (same) begin
      if (four_ac <= bsq_w) begin
        dmag = bsq_w - four_ac;
      end else begin
        dmag = four_ac - bsq_w;
        dneg = 1'b1;
      end
    end else begin
      dmag = four_ac + bsq_w;
    end

    item.a_neg    = a_neg;
    item.a_mag    = a_mag;
    item.b        = b1;
    item.is_small = dmag < qrs_pkg::SmallLimit;
    item.rad      = item.is_small ? {dmag[47:0], 16'h0000} : dmag[65:2];
    if (a_zero) item.rcase = qrs_pkg::CASE_AZERO;
    else if (dmag == '0) item.rcase = qrs_pkg::CASE_DOUBLE;
    else if (dneg) item.rcase = qrs_pkg::CASE_COMPLEX;
    else item.rcase = qrs_pkg::CASE_REAL;
  end

endmodule

[hw/rtl/qrs_queue.sv]
`timescale 1ns / 1ps
module qrs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  qrs_pkg::item_t wr_item,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output qrs_pkg::item_t rd_item
);

  qrs_pkg::item_t mem [2];
  logic           wptr, rptr;
  logic [1:0]     count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign rd_item  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wr_item;
  end

endmodule

[hw/rtl/qrs_div.sv]
`timescale 1ns / 1ps
module qrs_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [qrs_pkg::NumW-1:0]   num,
  input  logic                       neg,
  input  logic [qrs_pkg::MagW-1:0]   den,
  output logic [qrs_pkg::QuoW-1:0]   quo,
  output logic                       ovf,
  output logic                       neg_out
);

  localparam int N = qrs_pkg::DivSteps;

  logic [qrs_pkg::DivW-1:0] rem [N+1];
  logic [qrs_pkg::MagW-1:0] dd  [N+1];
  logic [qrs_pkg::QuoW-1:0] q   [N+1];
  logic                     ov  [N+1];
  logic                     ng  [N+1];

  // Quotients of 2^33 or more saturate anyway: flag them up front.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= qrs_pkg::DivW'(num);
      ov[0]  <= qrs_pkg::DivW'(num) >= (qrs_pkg::DivW'(den) << N);
      dd[0]  <= den;
      ng[0]  <= neg;
      q[0]   <= '0;
    end
  end

  for (genvar i = 1; i <= N; i++) begin : g_step
    localparam int Sh = N - i;
    logic [qrs_pkg::DivW-1:0] dsh;
    logic                     ge;
    assign dsh = qrs_pkg::DivW'(dd[i-1]) << Sh;
    assign ge  = rem[i-1] >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? rem[i-1] - dsh : rem[i-1];
        q[i]   <= {q[i-1][qrs_pkg::QuoW-2:0], ge};
        dd[i]  <= dd[i-1];
        ov[i]  <= ov[i-1];
        ng[i]  <= ng[i-1];
      end
    end
  end

  assign quo     = q[N];
  assign ovf     = ov[N];
  assign neg_out = ng[N];

endmodule

[hw/rtl/qrs_back.sv]
`timescale 1ns / 1ps
module qrs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  qrs_pkg::item_t q_item,
  output logic           pop,
  qrs_out_if.source      roots
);

  localparam int NS = qrs_pkg::SqrtSteps;
  localparam int ND = qrs_pkg::DivSteps + 1;

  logic en;

  qrs_pkg::item_t          it   [NS+1];
  logic [33:0]             rem  [NS+1];
  logic [qrs_pkg::RootW-1:0] root [NS+1];
  logic                    sv   [NS+1];

  logic                    nv;
  qrs_pkg::root_case_t     ncase;
  logic [qrs_pkg::NumW-1:0] num1, num2;
  logic                    neg1, neg2;
  logic [qrs_pkg::MagW-1:0] nden;

  logic                    dv [ND];
  qrs_pkg::root_case_t     dc [ND];

  logic [qrs_pkg::QuoW-1:0] quo1, quo2;
  logic                    ovf1, ovf2, ng1, ng2;

  // Whole back end advances together; stall only when the result is held.
  assign en  = !roots.valid || roots.ready;
  assign pop = q_valid && en;

  // Square root, one result bit per stage.
  always_ff @(posedge clk) begin
    if (en) begin
      it[0]   <= q_item;
      rem[0]  <= '0;
      root[0] <= '0;
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_sqrt
    logic [35:0]    r2, t;
    logic           ge;
    qrs_pkg::item_t nx;
    assign r2 = {rem[j], it[j].rad[qrs_pkg::RadW-1 -: 2]};
    assign t  = {2'b00, root[j], 2'b01};
    assign ge = r2 >= t;
    always_comb begin
      nx     = it[j];
      nx.rad = {it[j].rad[qrs_pkg::RadW-3:0], 2'b00};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        it[j+1]   <= nx;
        rem[j+1]  <= ge ? 34'(r2 - t) : r2[33:0];
        root[j+1] <= {root[j][qrs_pkg::RootW-2:0], ge};
      end
    end
  end

  // Numerators: -b scaled to the root's units, plus or minus the root.
  logic [32:0]        s_full;
  logic signed [47:0] nbx, nb, s48, n1, n2;
  logic               d2neg;
  logic [47:0]        m1, m2;

  always_comb begin
    qrs_pkg::item_t cur;
    cur    = it[NS];
    s_full = cur.is_small ? {1'b0, root[NS]} : {root[NS], 1'b0};
    s48    = 48'($signed({1'b0, s_full}));
    nbx    = 48'(cur.b);
    nb     = cur.is_small ? -(nbx <<< 8) : -nbx;
    d2neg  = cur.a_neg;
    case (cur.rcase)
      qrs_pkg::CASE_REAL: begin
        n1 = nb + s48;
        n2 = nb - s48;
      end
      qrs_pkg::CASE_COMPLEX: begin
        n1    = nb;
        n2    = s48;
        d2neg = 1'b0;
      end
      default: begin
        n1 = nb;
        n2 = nb;
      end
    endcase
    m1 = n1[47] ? 48'(-n1) : 48'(n1);
    m2 = n2[47] ? 48'(-n2) : 48'(n2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ncase <= it[NS].rcase;
      nden  <= it[NS].a_mag;
      neg1  <= n1[47] ^ it[NS].a_neg;
      neg2  <= n2[47] ^ d2neg;
      num1  <= qrs_pkg::NumW'(m1) << (it[NS].is_small ? qrs_pkg::ShiftSmall
                                                      : qrs_pkg::ShiftLarge);
      num2  <= qrs_pkg::NumW'(m2) << (it[NS].is_small ? qrs_pkg::ShiftSmall
                                                      : qrs_pkg::ShiftLarge);
    end
  end

  qrs_div u_div_first (
    .clk(clk), .en(en), .num(num1), .neg(neg1), .den(nden),
    .quo(quo1), .ovf(ovf1), .neg_out(ng1)
  );

  qrs_div u_div_second (
    .clk(clk), .en(en), .num(num2), .neg(neg2), .den(nden),
    .quo(quo2), .ovf(ovf2), .neg_out(ng2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dc[0] <= ncase;
      for (int i = 1; i < ND; i++) dc[i] <= dc[i-1];
    end
  end

  // Valid bits for every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NS; i++) sv[i] <= 1'b0;
      for (int i = 0; i < ND; i++) dv[i] <= 1'b0;
      nv          <= 1'b0;
      roots.valid <= 1'b0;
    end else if (en) begin
      sv[0] <= q_valid;
      for (int i = 1; i <= NS; i++) sv[i] <= sv[i-1];
      nv    <= sv[NS];
      dv[0] <= nv;
      for (int i = 1; i < ND; i++) dv[i] <= dv[i-1];
      roots.valid <= dv[ND-1];
    end
  end

  // Sign, saturate, and zero the degenerate case.
  logic               sg1, sg2, st1, st2;
  logic signed [31:0] v1, v2;

  always_comb begin
    sg1 = ng1 && (ovf1 || quo1 != '0);
    sg2 = ng2 && (ovf2 || quo2 != '0);
    st1 = ovf1 || (sg1 ? quo1 > qrs_pkg::QuoMinMag : quo1 > qrs_pkg::QuoMaxPos);
    st2 = ovf2 || (sg2 ? quo2 > qrs_pkg::QuoMinMag : quo2 > qrs_pkg::QuoMaxPos);
    if (st1) v1 = sg1 ? qrs_pkg::ValMin : qrs_pkg::ValMax;
    else v1 = sg1 ? 32'(-quo1) : 32'(quo1);
    if (st2) v2 = sg2 ? qrs_pkg::ValMin : qrs_pkg::ValMax;
    else v2 = sg2 ? 32'(-quo2) : 32'(quo2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roots.root_case <= dc[ND-1];
      if (dc[ND-1] == qrs_pkg::CASE_AZERO) begin
        roots.first_value  <= '0;
        roots.second_value <= '0;
        roots.saturated    <= 1'b0;
      end else begin
        roots.first_value  <= v1;
        roots.second_value <= v2;
        roots.saturated    <= st1 || st2;
      end
    end
  end

endmodule

[hw/rtl/quadratic_root_solver_core.sv]
`timescale 1ns / 1ps
// Solves a*x^2 + b*x + c = 0 for signed Q8.8 coefficients and returns the
// case code with two Q16.16 saturated values. One coefficient set is taken
// every clock unless back-pressure from the result side fills the queue; a
// request passes the front registers, the queue, the square root, the
// numerator register, the dividers and the output register, in that order. The latency is set by the
// bit-per-stage square root and the two bit-per-stage dividers.
module quadratic_root_solver_core #(
  parameter int COEF_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  qrs_in_if.sink     coefs,
  qrs_out_if.source  roots
);

  // Front: register the request, form b^2 and |a||c|, classify.
  logic           push, full, pop, nonempty;
  qrs_pkg::item_t f_item, q_item;

  qrs_front #(.COEF_WIDTH(COEF_WIDTH)) u_front (
    .clk(clk), .rst(rst), .coefs(coefs),
    .push(push), .item(f_item), .full(full)
  );

  // Queue: hold classified requests so the front keeps going while the
  // back end stalls on the result side.
  qrs_queue u_queue (
    .clk(clk), .rst(rst),
    .push(push), .wr_item(f_item), .full(full),
    .pop(pop), .nonempty(nonempty), .rd_item(q_item)
  );

  // Back: square root, numerators, two dividers, saturation.
  qrs_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(nonempty), .q_item(q_item), .pop(pop),
    .roots(roots)
  );

  // Degenerate a: both values zero, no clipping.
  a_azero_zero: assert property (@(posedge clk) disable iff (rst)
    roots.valid && roots.root_case == qrs_pkg::CASE_AZERO |->
      roots.first_value == 32'sd0 && roots.second_value == 32'sd0 && !roots.saturated)
    else $error("zero a gave nonzero result");

  // A double root reports the same value twice.
  a_double_same: assert property (@(posedge clk) disable iff (rst)
    roots.valid && roots.root_case == qrs_pkg::CASE_DOUBLE |->
      roots.first_value == roots.second_value)
    else $error("double root values differ");

  // The imaginary magnitude is never negative.
  a_imag_pos: assert property (@(posedge clk) disable iff (rst)
    roots.valid && roots.root_case == qrs_pkg::CASE_COMPLEX |->
      !roots.second_value[31])
    else $error("negative imaginary magnitude");

  // A clipped result sits on a range limit.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    roots.valid && roots.saturated |->
      roots.first_value == qrs_pkg::ValMax || roots.first_value == qrs_pkg::ValMin ||
      roots.second_value == qrs_pkg::ValMax || roots.second_value == qrs_pkg::ValMin)
    else $error("saturated flag without limit value");

endmodule
